/* hw/rtl/dfd_pkg.sv */
package dfd_pkg;

   localparam int FRAME_BYTES  = 196608;
   localparam int MAX_AUDIO    = 1024;
   localparam logic [31:0] MAGIC_WORD = 32'h4643_444e;

   localparam int TOTAL_PIXELS = FRAME_BYTES / 2;
   localparam int BYTE_CNT_W   = $clog2(FRAME_BYTES + 1);
   localparam int PIX_CNT_W    = $clog2(TOTAL_PIXELS + 1);
   localparam int TOKEN_LEN_W  = 16;
   localparam int SUM_W        = ((PIX_CNT_W > TOKEN_LEN_W) ? PIX_CNT_W : TOKEN_LEN_W) + 1;
   localparam int ADDR_W       = 17;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      RK_PIXEL = 2'd0,
      RK_DONE  = 2'd1,
      RK_ERROR = 2'd2
   } rkind_type;

   typedef enum logic [2:0] {
      ERR_HEADER    = 3'd0,
      ERR_ENCODING  = 3'd1,
      ERR_RAW_SIZE  = 3'd2,
      ERR_TRUNCATED = 3'd3,
      ERR_OVERFLOW  = 3'd4,
      ERR_LENGTH    = 3'd5
   } err_type;

   localparam logic [31:0] ENC_RAW   = 32'd0;
   localparam logic [31:0] ENC_DELTA = 32'd1;

   typedef struct packed {
      rkind_type         result_kind;
      logic [ADDR_W-1:0] pixel_address;
      logic [15:0]       pixel_value;
      err_type           error_code;
      logic              last;
   } result_type;

   // up to two words produced per accepted input word
   typedef struct packed {
      logic [1:0]          count;
      result_type [1:0]    slot;
   } push_type;

endpackage

/* hw/rtl/dfd_req_if.sv */
interface dfd_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] magic_word;
   logic [31:0] encoding;
   logic [31:0] payload_bytes;
   logic [31:0] pixel_count;
   logic [31:0] audio_frames;
   logic [7:0]  data_byte;

   modport source (
      output valid, kind, magic_word, encoding, payload_bytes, pixel_count,
             audio_frames, data_byte,
      input  ready
   );
   modport sink (
      input  valid, kind, magic_word, encoding, payload_bytes, pixel_count,
             audio_frames, data_byte,
      output ready
   );
endinterface

/* hw/rtl/dfd_rsp_if.sv */
interface dfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [16:0] pixel_address;
   logic [15:0] pixel_value;
   logic [2:0]  error_code;
   logic        last;

   modport source (
      output valid, result_kind, pixel_address, pixel_value, error_code, last,
      input  ready
   );
   modport sink (
      input  valid, result_kind, pixel_address, pixel_value, error_code, last,
      output ready
   );
endinterface

/* hw/rtl/delta_frame_decoder.sv */
// A result word is written into the result queue as its input word is accepted; rsp shows the queue head.
// Throughput: one input word per cycle while the queue has space; one result word
// leaves per cycle while rsp is ready, so the two results of one input word leave in turn.
// The four-word result queue takes an input word whenever it holds two or fewer words.
// Reset is synchronous, active high: decoder goes idle awaiting a header, queue empties.
module delta_frame_decoder
   import dfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dfd_req_if.sink    req_bus,
   dfd_rsp_if.source  rsp_bus
);

   push_type push;
   logic     space_ok;

   dfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .space_ok (space_ok),
      .push     (push)
   );

   dfd_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_bus  (rsp_bus)
   );

endmodule

/* hw/rtl/dfd_front.sv */
module dfd_front
   import dfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dfd_req_if.sink    req_bus,
   input  logic       space_ok,
   output push_type   push
);

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_RAW     = 4'b0010,
      PH_TOKEN   = 4'b0100,
      PH_LITERAL = 4'b1000
   } phase_type;

   function automatic result_type mk_result(rkind_type k, logic [ADDR_W-1:0] a,
                                            logic [15:0] v, err_type e);
      result_type r;
      r.result_kind   = k;
      r.pixel_address = a;
      r.pixel_value   = v;
      r.error_code    = e;
      r.last          = 1'b0;
      return r;
   endfunction

   function automatic push_type push_add(push_type p, result_type r);
      push_type q;
      q = p;
      if (p.count == 2'd0) begin
         q.slot[0] = r;
      end else begin
         q.slot[1] = r;
      end
      q.count = p.count + 2'd1;
      return q;
   endfunction

   // delta frame end check after a token or a literal run
   function automatic push_type end_check(push_type p, logic [BYTE_CNT_W-1:0] bl,
                                          logic [PIX_CNT_W-1:0] pix);
      push_type q;
      q = p;
      if (bl == '0 && pix == PIX_CNT_W'(TOTAL_PIXELS)) begin
         q = push_add(p, mk_result(RK_DONE, '0, '0, ERR_HEADER));
      end else if (bl == '0 || pix >= PIX_CNT_W'(TOTAL_PIXELS)) begin
         q = push_add(p, mk_result(RK_ERROR, '0, '0, ERR_LENGTH));
      end
      return q;
   endfunction

   phase_type                phase_ff, phase_in;
   logic [7:0]               low_ff, low_in;
   logic                     half_ff, half_in;
   logic [BYTE_CNT_W-1:0]    bytes_ff, bytes_in;
   logic [PIX_CNT_W-1:0]     pix_ff, pix_in;
   logic [TOKEN_LEN_W-1:0]   lit_ff, lit_in;

   logic                     accept;
   logic [15:0]              word;
   logic [BYTE_CNT_W-1:0]    bl_dec;
   logic [TOKEN_LEN_W-1:0]   tok_len;
   logic [SUM_W-1:0]         tok_sum;
   logic [PIX_CNT_W-1:0]     pix_inc;
   logic [TOKEN_LEN_W-1:0]   lit_dec;
   logic                     hdr_bad;
   logic                     bl_end;
   logic                     skip_end;
   logic                     lit_end;
   push_type                 pq;

   assign req_bus.ready = space_ok;
   assign accept        = req_bus.valid & space_ok;

   assign word     = {req_bus.data_byte, low_ff};
   assign bl_dec   = (bytes_ff != '0) ? bytes_ff - BYTE_CNT_W'(1) : '0;
   assign tok_len  = {1'b0, word[14:0]} + TOKEN_LEN_W'(1);
   assign tok_sum  = SUM_W'(pix_ff) + SUM_W'(tok_len);
   assign pix_inc  = pix_ff + PIX_CNT_W'(1);
   assign lit_dec  = (lit_ff != '0) ? lit_ff - TOKEN_LEN_W'(1) : '0;
   assign bl_end   = (bl_dec == '0);
   assign skip_end = bl_end || (tok_sum[PIX_CNT_W-1:0] >= PIX_CNT_W'(TOTAL_PIXELS));
   assign lit_end  = bl_end || (pix_inc >= PIX_CNT_W'(TOTAL_PIXELS));
   assign hdr_bad  = (req_bus.magic_word != MAGIC_WORD)
                   || (req_bus.payload_bytes > 32'(FRAME_BYTES))
                   || (req_bus.pixel_count != 32'(TOTAL_PIXELS))
                   || (req_bus.audio_frames > 32'(MAX_AUDIO));

   always_comb begin
      phase_in = phase_ff;
      low_in   = low_ff;
      half_in  = half_ff;
      bytes_in = bytes_ff;
      pix_in   = pix_ff;
      lit_in   = lit_ff;
      pq       = '0;
      if (accept) begin
         if (!req_bus.kind) begin
            if (phase_ff != PH_IDLE) begin
               pq = push_add(pq, mk_result(RK_ERROR, '0, '0, ERR_TRUNCATED));
            end
            half_in  = 1'b0;
            low_in   = '0;
            pix_in   = '0;
            lit_in   = '0;
            bytes_in = '0;
            phase_in = PH_IDLE;
            if (hdr_bad) begin
               pq = push_add(pq, mk_result(RK_ERROR, '0, '0, ERR_HEADER));
            end else if (req_bus.encoding == ENC_RAW) begin
               if (req_bus.payload_bytes != 32'(FRAME_BYTES)) begin
                  pq = push_add(pq, mk_result(RK_ERROR, '0, '0, ERR_RAW_SIZE));
               end else begin
                  bytes_in = req_bus.payload_bytes[BYTE_CNT_W-1:0];
                  phase_in = PH_RAW;
               end
            end else if (req_bus.encoding != ENC_DELTA) begin
               pq = push_add(pq, mk_result(RK_ERROR, '0, '0, ERR_ENCODING));
            end else if (req_bus.payload_bytes == '0) begin
               pq = push_add(pq, mk_result(RK_ERROR, '0, '0, ERR_LENGTH));
            end else begin
               bytes_in = req_bus.payload_bytes[BYTE_CNT_W-1:0];
               phase_in = PH_TOKEN;
            end
         end else if (phase_ff != PH_IDLE) begin
            bytes_in = bl_dec;
            if (!half_ff) begin
               low_in  = req_bus.data_byte;
               half_in = 1'b1;
               if (bl_end) begin
                  phase_in = PH_IDLE;
                  if (phase_ff == PH_RAW) begin
                     pq = push_add(pq, mk_result(RK_DONE, '0, '0, ERR_HEADER));
                  end else begin
                     pq = push_add(pq, mk_result(RK_ERROR, '0, '0, ERR_TRUNCATED));
                  end
               end
            end else begin
               half_in = 1'b0;
               unique case (phase_ff)
                  PH_RAW: begin
                     if (pix_ff < PIX_CNT_W'(TOTAL_PIXELS)) begin
                        pq = push_add(pq, mk_result(RK_PIXEL, ADDR_W'(pix_ff), word,
                                                    ERR_HEADER));
                        pix_in = pix_inc;
                     end
                     if (bl_end) begin
                        pq = push_add(pq, mk_result(RK_DONE, '0, '0, ERR_HEADER));
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_TOKEN: begin
                     if (tok_sum > SUM_W'(TOTAL_PIXELS)) begin
                        pq = push_add(pq, mk_result(RK_ERROR, '0, '0, ERR_OVERFLOW));
                        phase_in = PH_IDLE;
                     end else if (word[15]) begin
                        pix_in = tok_sum[PIX_CNT_W-1:0];
                        pq     = end_check(pq, bl_dec, tok_sum[PIX_CNT_W-1:0]);
                        if (skip_end) begin
                           phase_in = PH_IDLE;
                        end
                     end else begin
                        lit_in   = tok_len;
                        phase_in = PH_LITERAL;
                        if (bl_end) begin
                           pq = push_add(pq, mk_result(RK_ERROR, '0, '0, ERR_TRUNCATED));
                           phase_in = PH_IDLE;
                        end
                     end
                  end
                  PH_LITERAL: begin
                     pq = push_add(pq, mk_result(RK_PIXEL, ADDR_W'(pix_ff), word,
                                                 ERR_HEADER));
                     pix_in = pix_inc;
                     lit_in = lit_dec;
                     if (lit_dec != '0) begin
                        if (bl_end) begin
                           pq = push_add(pq, mk_result(RK_ERROR, '0, '0, ERR_TRUNCATED));
                           phase_in = PH_IDLE;
                        end
                     end else begin
                        pq       = end_check(pq, bl_dec, pix_inc);
                        phase_in = lit_end ? PH_IDLE : PH_TOKEN;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end
      if (pq.count == 2'd1) begin
         pq.slot[0].last = 1'b1;
      end else if (pq.count == 2'd2) begin
         pq.slot[1].last = 1'b1;
      end
   end

   assign push = pq;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         half_ff  <= 1'b0;
         bytes_ff <= '0;
         pix_ff   <= '0;
         lit_ff   <= '0;
         low_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         half_ff  <= half_in;
         bytes_ff <= bytes_in;
         pix_ff   <= pix_in;
         lit_ff   <= lit_in;
         low_ff   <= low_in;
      end
   end

endmodule

/* hw/rtl/dfd_result_queue.sv */
module dfd_result_queue
   import dfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space_ok,
   dfd_rsp_if.source  rsp_bus
);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ff, wr_in;
   logic [QUEUE_AW-1:0]    rd_ff, rd_in;
   logic [QUEUE_CW-1:0]    count_ff, count_in;
   logic [QUEUE_AW-1:0]    wr_next;
   logic                   pop;
   result_type             head;

   assign space_ok = (count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2));
   assign pop      = rsp_bus.valid & rsp_bus.ready;
   assign wr_next  = wr_ff + QUEUE_AW'(1);
   assign wr_in    = wr_ff + QUEUE_AW'(push.count);
   assign rd_in    = rd_ff + QUEUE_AW'(pop);
   assign count_in = count_ff + QUEUE_CW'(push.count) - QUEUE_CW'(pop);

   assign head                  = entry_ff[rd_ff];
   assign rsp_bus.valid         = (count_ff != '0);
   assign rsp_bus.result_kind   = head.result_kind;
   assign rsp_bus.pixel_address = head.pixel_address;
   assign rsp_bus.pixel_value   = head.pixel_value;
   assign rsp_bus.error_code    = head.error_code;
   assign rsp_bus.last          = head.last;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.slot[0];
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.slot[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

/* dv/delta_frame_decoder_test.sv */
`timescale 1ns / 100ps

module delta_frame_decoder_test;
   import dfd_pkg::*;

   localparam int RANDOM_WORDS = 1120;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 16;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int MAX_RUN      = 32768;
   localparam int PRINT_LIMIT  = 20;

   localparam logic HEADER_WORD = 1'b0;
   localparam logic BYTE_WORD   = 1'b1;
   localparam err_type NO_ERR   = ERR_HEADER;

   typedef struct packed {
      logic        kind;
      logic [31:0] magic_word;
      logic [31:0] encoding;
      logic [31:0] payload_bytes;
      logic [31:0] pixel_count;
      logic [31:0] audio_frames;
      logic [7:0]  data_byte;
   } frame_word_type;

   typedef enum logic [1:0] {DEC_IDLE, DEC_RAW, DEC_TOKEN, DEC_LITERAL} dec_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dfd_req_if req_bus ();
   dfd_rsp_if rsp_bus ();

   delta_frame_decoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   frame_word_type drv_word  = '0;
   logic           drv_valid = 1'b0;
   logic           rcv_ready = 1'b0;

   assign req_bus.valid         = drv_valid;
   assign req_bus.kind          = drv_word.kind;
   assign req_bus.magic_word    = drv_word.magic_word;
   assign req_bus.encoding      = drv_word.encoding;
   assign req_bus.payload_bytes = drv_word.payload_bytes;
   assign req_bus.pixel_count   = drv_word.pixel_count;
   assign req_bus.audio_frames  = drv_word.audio_frames;
   assign req_bus.data_byte     = drv_word.data_byte;
   assign rsp_bus.ready         = rcv_ready;

   frame_word_type words_to_send [$];
   result_type     results_due [$];
   result_type     step_out [$];

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_armed     = 1'b0;
   int   hold_left      = HOLD_CYCLES;

   int mismatches     = 0;
   int words_accepted = 0;
   int results_seen   = 0;
   int pixels_seen    = 0;
   int frames_done    = 0;
   int frame_errors   = 0;
   int cycle_count    = 0;

   // decoder state
   dec_state_type dec_phase  = DEC_IDLE;
   logic [7:0]    low_held   = '0;
   logic          half_pend  = 1'b0;
   int unsigned   bytes_left = 0;
   int unsigned   pix_idx    = 0;
   int unsigned   lits_left  = 0;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] result %0d: %s", $time, results_seen, what);
   endtask

   task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
   endtask

   function automatic void put_result(rkind_type kind_code, int unsigned addr,
                                      logic [15:0] value, err_type code);
      result_type r;
      r.result_kind   = kind_code;
      r.pixel_address = addr[ADDR_W-1:0];
      r.pixel_value   = value;
      r.error_code    = code;
      r.last          = 1'b0;
      step_out.insert(step_out.size(), r);
   endfunction

   function automatic void close_with_error(err_type code);
      dec_phase = DEC_IDLE;
      put_result(RK_ERROR, 0, '0, code);
   endfunction

   function automatic void close_with_done();
      dec_phase = DEC_IDLE;
      put_result(RK_DONE, 0, '0, NO_ERR);
   endfunction

   function automatic void check_delta_end();
      if (bytes_left == 0) begin
         if (pix_idx == TOTAL_PIXELS) close_with_done();
         else close_with_error(ERR_LENGTH);
      end else if (pix_idx >= TOTAL_PIXELS) begin
         close_with_error(ERR_LENGTH);
      end
   endfunction

   // expected result words for one accepted input word
   function automatic void decode_word(frame_word_type w);
      logic [15:0] pair;
      int unsigned run;
      step_out.delete();
      if (w.kind == HEADER_WORD) begin
         if (dec_phase != DEC_IDLE) close_with_error(ERR_TRUNCATED);
         half_pend  = 1'b0;
         low_held   = '0;
         pix_idx    = 0;
         lits_left  = 0;
         bytes_left = 0;
         if (w.magic_word != MAGIC_WORD || w.payload_bytes > FRAME_BYTES
             || w.pixel_count != TOTAL_PIXELS || w.audio_frames > MAX_AUDIO) begin
            close_with_error(ERR_HEADER);
         end else if (w.encoding == ENC_RAW) begin
            if (w.payload_bytes != FRAME_BYTES) begin
               close_with_error(ERR_RAW_SIZE);
            end else begin
               bytes_left = w.payload_bytes;
               dec_phase  = DEC_RAW;
            end
         end else if (w.encoding != ENC_DELTA) begin
            close_with_error(ERR_ENCODING);
         end else if (w.payload_bytes == 0) begin
            close_with_error(ERR_LENGTH);
         end else begin
            bytes_left = w.payload_bytes;
            dec_phase  = DEC_TOKEN;
         end
      end else if (dec_phase != DEC_IDLE) begin
         if (bytes_left != 0) bytes_left--;
         if (!half_pend) begin
            low_held  = w.data_byte;
            half_pend = 1'b1;
            if (bytes_left == 0) begin
               if (dec_phase == DEC_RAW) close_with_done();
               else close_with_error(ERR_TRUNCATED);
            end
         end else begin
            half_pend = 1'b0;
            pair = {w.data_byte, low_held};
            case (dec_phase)
               DEC_RAW: begin
                  if (pix_idx < TOTAL_PIXELS) begin
                     put_result(RK_PIXEL, pix_idx, pair, NO_ERR);
                     pix_idx++;
                  end
                  if (bytes_left == 0) close_with_done();
               end
               DEC_TOKEN: begin
                  run = pair[14:0] + 1;
                  if (pix_idx + run > TOTAL_PIXELS) begin
                     close_with_error(ERR_OVERFLOW);
                  end else if (pair[15]) begin
                     pix_idx += run;
                     check_delta_end();
                  end else begin
                     lits_left = run;
                     dec_phase = DEC_LITERAL;
                     if (bytes_left == 0) close_with_error(ERR_TRUNCATED);
                  end
               end
               default: begin
                  put_result(RK_PIXEL, pix_idx, pair, NO_ERR);
                  pix_idx++;
                  if (lits_left != 0) lits_left--;
                  if (lits_left != 0) begin
                     if (bytes_left == 0) close_with_error(ERR_TRUNCATED);
                  end else begin
                     dec_phase = DEC_TOKEN;
                     check_delta_end();
                  end
               end
            endcase
         end
      end
      if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) results_due.insert(results_due.size(), step_out[i]);
   endfunction

   function automatic void queue_header(logic [31:0] magic, logic [31:0] enc,
                                        logic [31:0] plen, logic [31:0] pcnt,
                                        logic [31:0] audio);
      frame_word_type w;
      w.kind          = HEADER_WORD;
      w.magic_word    = magic;
      w.encoding      = enc;
      w.payload_bytes = plen;
      w.pixel_count   = pcnt;
      w.audio_frames  = audio;
      w.data_byte     = 8'($urandom);
      words_to_send.insert(words_to_send.size(), w);
   endfunction

   function automatic void queue_frame_start(logic [31:0] enc, logic [31:0] plen);
      queue_header(MAGIC_WORD, enc, plen, TOTAL_PIXELS, $urandom_range(MAX_AUDIO, 0));
   endfunction

   // header fields of a byte word carry junk; the block must ignore them
   function automatic void queue_byte(logic [7:0] b);
      frame_word_type w;
      w.kind          = BYTE_WORD;
      w.magic_word    = $urandom;
      w.encoding      = $urandom;
      w.payload_bytes = $urandom;
      w.pixel_count   = $urandom;
      w.audio_frames  = $urandom;
      w.data_byte     = b;
      words_to_send.insert(words_to_send.size(), w);
   endfunction

   // bytes go out low byte first
   function automatic void queue_bytes(int count, logic [63:0] packed_le);
      for (int i = 0; i < count; i++) queue_byte(packed_le[8*i +: 8]);
   endfunction

   function automatic int queue_random_frame();
      logic [7:0]  stream [$];
      logic [15:0] tok;
      int unsigned left_px, run, cap, plen, sent, pick, n0, sz, i;
      n0 = words_to_send.size();
      pick = $urandom_range(9, 0);
      if (pick == 9) begin
         case ($urandom_range(6, 0))
            0: queue_header($urandom, $urandom, $urandom, $urandom, $urandom);
            1: queue_header($urandom, ENC_DELTA, $urandom_range(FRAME_BYTES, 0),
                            TOTAL_PIXELS, 0);
            2: queue_header(MAGIC_WORD, ENC_DELTA,
                            $urandom_range(32'hffff_ffff, FRAME_BYTES + 1), TOTAL_PIXELS, 0);
            3: queue_header(MAGIC_WORD, ENC_DELTA, $urandom_range(FRAME_BYTES, 0),
                            $urandom, $urandom_range(MAX_AUDIO, 0));
            4: queue_header(MAGIC_WORD, $urandom, $urandom_range(FRAME_BYTES, 0),
                            TOTAL_PIXELS, $urandom_range(32'hffff_ffff, MAX_AUDIO + 1));
            5: queue_frame_start($urandom_range(32'hffff_ffff, ENC_DELTA + 1),
                                 $urandom_range(FRAME_BYTES, 0));
            default: begin
               if ($urandom_range(1, 0)) begin
                  queue_frame_start(ENC_RAW, FRAME_BYTES);
                  repeat ($urandom_range(8, 1)) queue_byte(8'($urandom));
               end else begin
                  queue_frame_start(ENC_RAW, $urandom_range(FRAME_BYTES - 1, 0));
               end
            end
         endcase
         repeat ($urandom_range(3, 0)) queue_byte(8'($urandom));
         return words_to_send.size() - n0;
      end

      // token stream covering the whole frame
      left_px = TOTAL_PIXELS;
      while (left_px != 0) begin
         if ($urandom_range(2, 0) == 0) begin
            run = $urandom_range((left_px < 6) ? left_px : 6, 1);
            tok = 16'(run - 1);
            stream.insert(stream.size(), tok[7:0]);
            stream.insert(stream.size(), tok[15:8]);
            repeat (run) begin
               stream.insert(stream.size(), 8'($urandom));
               stream.insert(stream.size(), 8'($urandom));
            end
         end else begin
            cap = (left_px < MAX_RUN) ? left_px : MAX_RUN;
            run = ($urandom_range(3, 0) == 0) ? $urandom_range(cap, 1) : cap;
            tok = 16'h8000 | 16'(run - 1);
            stream.insert(stream.size(), tok[7:0]);
            stream.insert(stream.size(), tok[15:8]);
         end
         left_px -= run;
      end

      sz   = stream.size();
      plen = sz;
      sent = sz;
      case (pick)
         5: plen = $urandom_range(sz - 1, 1);             // payload ends early
         6: begin                                         // payload runs past the frame
            plen = sz + $urandom_range(6, 1);
            while (stream.size() < plen) stream.insert(stream.size(), 8'($urandom));
            sent = plen;
         end
         7: stream[$urandom_range(sz - 1, 0)] = 8'($urandom);
         8: sent = $urandom_range(sz - 1, 1);             // cut off by the next header
         default: ;
      endcase
      queue_frame_start(ENC_DELTA, plen);
      for (i = 0; i < sent; i++) queue_byte(stream[i]);
      return words_to_send.size() - n0;
   endfunction

   task automatic wait_drained();
      int waited;
      while (words_to_send.size() != 0 || drv_valid) @(negedge clock);
      waited = 0;
      while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(negedge clock);
      if (results_due.size() != 0) begin
         report_mismatch($sformatf("%0d result words never arrived", results_due.size()));
         results_due.delete();
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_bus.ready) begin
            decode_word(drv_word);
            words_accepted++;
         end
         if (!drv_valid || req_bus.ready) begin
            if (words_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               drv_word  <= words_to_send[0];
               drv_valid <= 1'b1;
               words_to_send.delete(0);
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, once armed
   always @(posedge clock) begin
      if (hold_armed && hold_left != 0) hold_left <= hold_left - 1;
   end

   // receiver and checker
   always @(posedge clock) begin : watch_rsp
      result_type want;
      if (reset) begin
         rcv_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rcv_ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               report_mismatch("result word with nothing pending");
            end else begin
               want = results_due[0];
               results_due.delete(0);
               check_field("result_kind", 32'(rsp_bus.result_kind),
                           32'(want.result_kind));
               check_field("pixel_address", 32'(rsp_bus.pixel_address),
                           32'(want.pixel_address));
               check_field("pixel_value", 32'(rsp_bus.pixel_value),
                           32'(want.pixel_value));
               check_field("error_code", 32'(rsp_bus.error_code),
                           32'(want.error_code));
               check_field("last", 32'(rsp_bus.last), 32'(want.last));
               case (want.result_kind)
                  RK_PIXEL: pixels_seen++;
                  RK_DONE:  frames_done++;
                  default:  frame_errors++;
               endcase
            end
         end
         rcv_ready <= !(hold_armed && hold_left != 0)
                      && ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("delta_frame_decoder: mismatch");
      $finish;
   end

   initial begin : stimulus
      int ph, budget;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_byte(8'hff);                                  // no frame open
      queue_header(~MAGIC_WORD, ENC_DELTA + 1, 32'd16, TOTAL_PIXELS, 32'd0);
      queue_header(MAGIC_WORD, ENC_DELTA, 32'd4, TOTAL_PIXELS, MAX_AUDIO + 1);
      queue_header(MAGIC_WORD, ENC_RAW, FRAME_BYTES - 1, TOTAL_PIXELS, MAX_AUDIO);
      queue_header(MAGIC_WORD, 32'hffff_ffff, 32'd0, TOTAL_PIXELS, 32'd0);
      queue_header(MAGIC_WORD, ENC_DELTA, 32'd0, TOTAL_PIXELS, 32'd0);
      queue_header(MAGIC_WORD, ENC_DELTA, 32'd3, TOTAL_PIXELS, 32'd0);
      queue_bytes(3, 64'h00_ffff);                        // ends inside a token
      queue_header(MAGIC_WORD, ENC_DELTA, 32'd8, TOTAL_PIXELS, 32'd0);
      queue_bytes(4, 64'h55aa_0001);                      // literal run left open
      queue_header(MAGIC_WORD, ENC_RAW, FRAME_BYTES, TOTAL_PIXELS, 32'd0);
      queue_bytes(2, 64'h00ff);
      queue_header(MAGIC_WORD, ENC_RAW, FRAME_BYTES, TOTAL_PIXELS + 1, 32'hffff_ffff);
      queue_header(MAGIC_WORD, ENC_DELTA, 32'd8, TOTAL_PIXELS, MAX_AUDIO);
      queue_bytes(8, 64'h8001_fffe_ffff_ffff);            // last token overruns the frame
      wait_drained();

      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 19 : 0;
         recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 19 : 0;
         if (ph == 0) hold_armed = 1'b1;
         budget = 0;
         while (budget < RANDOM_WORDS / 4) budget += queue_random_frame();
         wait_drained();
      end

      $display("covered %0d input words and %0d result words (%0d pixel writes)",
               words_accepted, results_seen, pixels_seen);
      $display("frames closed: %0d complete, %0d with errors, over four pacing phases",
               frames_done, frame_errors);
      if (mismatches == 0) begin
         $display("delta_frame_decoder: match");
      end else begin
         $display("delta_frame_decoder: mismatch");
      end
      $finish;
   end

endmodule
